>>> design/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked property, held off while reset is asserted
`define CLNS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// checked property, also active during reset
`define CLNS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define CLNS_ASSERT(label, clk, rst_n, prop)
`define CLNS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> design/clns_pkg.sv
`default_nettype none

package clns_pkg;

    // field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 2;
    localparam int CFG_W   = 9;
    localparam int NIB_W   = 4;
    localparam int WAIT_W  = 14;

    // op codes on the input stream
    localparam logic [OP_W-1:0] OP_PRINT  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_CURSOR = 2'd2;
    localparam logic [OP_W-1:0] OP_INIT   = 2'd3;

    // lcd command bytes and addresses
    localparam logic [7:0]       CMD_CLEAR  = 8'h01;
    localparam logic [7:0]       LINE1_BASE = 8'h80;
    localparam logic [7:0]       LINE2_BASE = 8'h80 + 8'h40;
    localparam logic [ROW_W-1:0] ROW_LINE2  = 2'd2;

    // waits in microseconds
    localparam logic [CFG_W-1:0]  STD_WAIT_RESET = 9'd40;
    localparam logic [WAIT_W:0]   CLEAR_FACTOR   = 15'd41;
    localparam logic [WAIT_W-1:0] WAIT_MAX       = 14'd16383;
    localparam logic [WAIT_W-1:0] CLR_WAIT_RESET = 14'(40 * 41);
    localparam logic [WAIT_W-1:0] POWERUP_WAIT   = 14'd5000 + 14'd10000;
    localparam logic [WAIT_W-1:0] INIT_GAP1      = 14'd4100;
    localparam logic [WAIT_W-1:0] INIT_GAP2      = 14'd100;

    // step counter
    localparam int              INIT_STEPS = 17;
    localparam int              STEP_W     = $clog2(INIT_STEPS);
    localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_STEPS - 1);
    localparam logic [STEP_W-1:0] BYTE_LAST = STEP_W'(1);

    // command queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // classified command
    typedef enum logic [1:0] {
        K_DATA,
        K_CMD,
        K_CLEAR,
        K_INIT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_cmd;

    // one transfer step on the lcd side
    typedef struct packed {
        logic              rs;
        logic              strobe;
        logic [NIB_W-1:0]  nibble;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_step;

    // wait selection for one step
    typedef enum logic [2:0] {
        W_STD,
        W_CLR,
        W_PWR,
        W_GAP1,
        W_GAP2
    } t_wsel;

    // back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_bk_state;

    // build the transfer step for a command at a given step index
    function automatic t_step step_of(input t_cmd cmd, input logic [STEP_W-1:0] step,
                                      input logic [WAIT_W-1:0] std_wait,
                                      input logic [WAIT_W-1:0] clr_wait);
        t_step            s;
        t_wsel            wsel;
        logic             strobe;
        logic [NIB_W-1:0] nib;
        s      = '0;
        wsel   = W_STD;
        strobe = 1'b1;
        nib    = '0;
        if (cmd.kind == K_INIT) begin
            // fixed power-up sequence
            unique case (step)
                5'd0:  begin strobe = 1'b0; nib = 4'h0; wsel = W_PWR;  end
                5'd1:  begin nib = 4'h3; wsel = W_STD; end
                5'd2:  begin strobe = 1'b0; nib = 4'h0; wsel = W_GAP1; end
                5'd3:  begin nib = 4'h3; wsel = W_STD; end
                5'd4:  begin strobe = 1'b0; nib = 4'h0; wsel = W_GAP2; end
                5'd5:  begin nib = 4'h3; wsel = W_STD; end
                5'd6:  begin nib = 4'h2; wsel = W_STD; end
                5'd7:  begin nib = 4'h2; wsel = W_STD; end
                5'd8:  begin nib = 4'hB; wsel = W_STD; end
                5'd9:  begin nib = 4'h0; wsel = W_STD; end
                5'd10: begin nib = 4'h8; wsel = W_STD; end
                5'd11: begin nib = 4'h0; wsel = W_CLR; end
                5'd12: begin nib = 4'h1; wsel = W_CLR; end
                5'd13: begin nib = 4'h0; wsel = W_STD; end
                5'd14: begin nib = 4'h6; wsel = W_STD; end
                5'd15: begin nib = 4'h0; wsel = W_STD; end
                5'd16: begin nib = 4'hC; wsel = W_STD; end
                default: begin nib = 4'h0; wsel = W_STD; end
            endcase
            s.last = (step == INIT_LAST);
            s.rs   = 1'b0;
        end else begin
            // one byte, high nibble first
            nib    = (step == '0) ? cmd.value[7:4] : cmd.value[3:0];
            wsel   = (cmd.kind == K_CLEAR) ? W_CLR : W_STD;
            s.last = (step == BYTE_LAST);
            s.rs   = (cmd.kind == K_DATA);
        end
        s.strobe = strobe;
        s.nibble = nib;
        unique case (wsel)
            W_STD:   s.wait_us = std_wait;
            W_CLR:   s.wait_us = clr_wait;
            W_PWR:   s.wait_us = POWERUP_WAIT;
            W_GAP1:  s.wait_us = INIT_GAP1;
            W_GAP2:  s.wait_us = INIT_GAP2;
            default: s.wait_us = std_wait;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> design/char_lcd_nibble_sequencer.sv
// commands go via holding stage, queue and command register; then one step per cycle unless stalled
// a character, clear or cursor command gives 2 steps, an initialise command gives 17
// queued commands follow without a gap, the next one taken while the last step is issued
// a two-entry command queue and a holding stage let the input run ahead of the sequencer
// synchronous active-low reset empties the pipeline and sets the standard wait to 40 us
`default_nettype none

module char_lcd_nibble_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write
    input  wire logic        i_cfg_we,
    input  wire logic [8:0]  i_cfg_wdata,   // standard_wait_us
    // command input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // char_code[7:0], column[13:8], row[15:14]
    input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
    // transfer step output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // nibble[3:0], wait_us[17:4], zero[23:18]
    output logic [1:0]       m_axis_tuser,  // register_select[0], strobe_res[1]
    output logic             m_axis_tlast   // last
);
    import clns_pkg::*;

    logic [CFG_W-1:0]  r_std_wait;
    logic [WAIT_W-1:0] r_clr_wait;
    logic [WAIT_W:0]   clr_prod;
    logic [WAIT_W-1:0] clr_sat;
    logic              f_valid;
    logic              f_ready;
    t_cmd              f_cmd;
    logic              q_valid;
    logic              q_ready;
    t_cmd              q_cmd;
    t_step             b_step;

    // long clear wait, saturated, worked out at configuration time
    assign clr_prod = (WAIT_W+1)'(i_cfg_wdata) * CLEAR_FACTOR;
    assign clr_sat  = (clr_prod > {1'b0, WAIT_MAX}) ? WAIT_MAX : clr_prod[WAIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std_wait <= STD_WAIT_RESET;
            r_clr_wait <= CLR_WAIT_RESET;
        end else if (i_cfg_we) begin
            r_std_wait <= i_cfg_wdata;
            r_clr_wait <= clr_sat;
        end
    end

    // command intake and classification
    clns_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_char_code (s_axis_tdata[7:0]),
        .i_column    (s_axis_tdata[13:8]),
        .i_row       (s_axis_tdata[15:14]),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_cmd       (f_cmd)
    );

    // decoupling queue
    clns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    // step sequencer
    clns_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_std_wait ({{(WAIT_W-CFG_W){1'b0}}, r_std_wait}),
        .i_clr_wait (r_clr_wait),
        .i_valid    (q_valid),
        .o_ready    (q_ready),
        .i_cmd      (q_cmd),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_step     (b_step)
    );

    // output packing
    assign m_axis_tdata = {6'b0, b_step.wait_us, b_step.nibble};
    assign m_axis_tuser = {b_step.strobe, b_step.rs};
    assign m_axis_tlast = b_step.last;

endmodule

`default_nettype wire

>>> design/clns_front.sv
`default_nettype none

module clns_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [clns_pkg::OP_W-1:0]     i_op,
    input  wire logic [clns_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [clns_pkg::COL_W-1:0]    i_column,
    input  wire logic [clns_pkg::ROW_W-1:0]    i_row,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output clns_pkg::t_cmd                     o_cmd
);
    import clns_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_cmd  r_cmd;
    t_cmd  cls_cmd;
    logic  accept;
    logic  push;

    // classify the incoming command
    always_comb begin
        cls_cmd = '0;
        unique case (i_op)
            OP_PRINT: begin
                cls_cmd.kind  = K_DATA;
                cls_cmd.value = i_char_code;
            end
            OP_CLEAR: begin
                cls_cmd.kind  = K_CLEAR;
                cls_cmd.value = CMD_CLEAR;
            end
            OP_CURSOR: begin
                cls_cmd.kind  = K_CMD;
                cls_cmd.value = ((i_row == ROW_LINE2) ? LINE2_BASE : LINE1_BASE)
                              + {2'b00, i_column};
            end
            OP_INIT: begin
                cls_cmd.kind  = K_INIT;
                cls_cmd.value = 8'h00;
            end
            default: begin
                cls_cmd.kind  = K_INIT;
                cls_cmd.value = 8'h00;
            end
        endcase
    end

    // one holding stage ahead of the queue
    assign push    = r_valid && i_ready;
    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cls_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

`default_nettype wire

>>> design/clns_queue.sv
`default_nettype none
`include "assert_macros.svh"

module clns_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire clns_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output clns_pkg::t_cmd      o_cmd
);
    import clns_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // fill count stays in range and agrees with the pointers
    `CLNS_ASSERT(a_q_count_range, i_clk, i_rst_n, r_count <= QCNT_W'(QDEPTH))
    `CLNS_ASSERT(a_q_ptr_gap, i_clk, i_rst_n, !(o_valid && o_ready) |-> (r_wr_ptr == r_rd_ptr))

endmodule

`default_nettype wire

>>> design/clns_back.sv
`default_nettype none
`include "assert_macros.svh"

module clns_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [clns_pkg::WAIT_W-1:0]    i_std_wait,
    input  wire logic [clns_pkg::WAIT_W-1:0]    i_clr_wait,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire clns_pkg::t_cmd                 i_cmd,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output clns_pkg::t_step                     o_step
);
    import clns_pkg::*;

    t_bk_state         r_state;
    t_bk_state         n_state;
    t_cmd              r_cmd;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              n_out_valid;
    t_step             r_out;
    t_step             cur;
    logic              load;
    logic              emit;
    logic              pop;

    // current step from the active command
    assign cur  = step_of(r_cmd, r_step, i_std_wait, i_clr_wait);
    assign load = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (load && cur.last && !i_valid) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        emit = 1'b0;
        pop  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                pop = i_valid;
            end
            BK_RUN: begin
                emit = load;
                pop  = load && cur.last && i_valid;
            end
            default: begin
                emit = 1'b0;
                pop  = 1'b0;
            end
        endcase
    end

    assign o_ready = pop;

    // output register hold and release
    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (pop) begin
                r_step <= '0;
            end else if (emit) begin
                // back to the first step once the run is done
                r_step <= cur.last ? '0 : r_step + 1'b1;
            end
        end
    end

    // command and output payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out <= cur;
        end
    end

    assign o_valid = r_out_valid;
    assign o_step  = r_out;

    // step index never runs past the longest sequence
    `CLNS_ASSERT(a_bk_step_range, i_clk, i_rst_n, r_step <= INIT_LAST)
    // byte commands end after two nibbles
    `CLNS_ASSERT(a_bk_byte_short, i_clk, i_rst_n,
        (r_state == BK_RUN && r_cmd.kind != K_INIT) |-> (r_step <= BYTE_LAST))

endmodule

`default_nettype wire

>>> dv/tb.sv
module tb;
    import clns_pkg::*;

    // lcd command bytes sent by the power-up sequence
    localparam logic [7:0]       FUNC_SET_4BIT = 8'h2B;
    localparam logic [7:0]       DISPLAY_OFF   = 8'h08;
    localparam logic [7:0]       ENTRY_INC     = 8'h06;
    localparam logic [7:0]       DISPLAY_ON    = 8'h0C;
    localparam logic [NIB_W-1:0] WAKE_NIB      = 4'h3;
    localparam logic [NIB_W-1:0] MODE_4BIT_NIB = 4'h2;

    localparam int SCRIPT_LEN   = 20;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 80;
    localparam int MAX_PRINTED  = 30;

    // directed stimulus row, with an optional register write before it
    typedef struct packed {
        logic              wr_cfg;
        logic [CFG_W-1:0]  cfg;
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              typed;
        logic              rs;
        logic [NIB_W-1:0]  hi;
        logic [NIB_W-1:0]  lo;
        logic [WAIT_W-1:0] wait_us;
    } t_script_row;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;  // char_code[7:0], column[13:8], row[15:14]
    logic [1:0]        s_axis_tuser  = '0;  // op[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;        // nibble[3:0], wait_us[17:4], zero[23:18]
    logic [1:0]        m_axis_tuser;        // register_select[0], strobe_res[1]
    logic              m_axis_tlast;

    t_step             steps_pending[$];
    logic [CFG_W-1:0]  std_wait_us = STD_WAIT_RESET;
    int                mismatch_count = 0;

    // receiver stall pattern state
    int                stall_mode = 0;
    int                stall_left = 0;
    int                stall_tick = 0;

    char_lcd_nibble_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // expected step builders
    function automatic void add_step(input logic rs, input logic strobe,
                                     input logic [NIB_W-1:0] nib,
                                     input logic [WAIT_W-1:0] wait_us,
                                     input logic last);
        t_step s;
        s.rs      = rs;
        s.strobe  = strobe;
        s.nibble  = nib;
        s.wait_us = wait_us;
        s.last    = last;
        steps_pending.push_back(s);
    endfunction

    function automatic void add_byte(input logic rs, input logic [7:0] value,
                                     input logic [WAIT_W-1:0] wait_us, input logic last);
        add_step(rs, 1'b1, value[7:4], wait_us, 1'b0);
        add_step(rs, 1'b1, value[3:0], wait_us, last);
    endfunction

    // long wait after a clear, saturated to the field width
    function automatic logic [WAIT_W-1:0] clear_wait_us();
        int w;
        w = int'(std_wait_us) * 41;
        return (w > int'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(w);
    endfunction

    // expand one lcd command into its transfer steps
    function automatic void expand_command(input logic [OP_W-1:0] op,
                                           input logic [CHAR_W-1:0] ch,
                                           input logic [COL_W-1:0] col,
                                           input logic [ROW_W-1:0] row);
        logic [WAIT_W-1:0] sw;
        logic [7:0]        addr;
        sw   = WAIT_W'(std_wait_us);
        addr = ((row == ROW_LINE2) ? LINE2_BASE : LINE1_BASE) + 8'(col);
        case (op)
            OP_PRINT:  add_byte(1'b1, ch, sw, 1'b1);
            OP_CLEAR:  add_byte(1'b0, CMD_CLEAR, clear_wait_us(), 1'b1);
            OP_CURSOR: add_byte(1'b0, addr, sw, 1'b1);
            default: begin
                add_step(1'b0, 1'b0, '0, POWERUP_WAIT, 1'b0);
                add_step(1'b0, 1'b1, WAKE_NIB, sw, 1'b0);
                add_step(1'b0, 1'b0, '0, INIT_GAP1, 1'b0);
                add_step(1'b0, 1'b1, WAKE_NIB, sw, 1'b0);
                add_step(1'b0, 1'b0, '0, INIT_GAP2, 1'b0);
                add_step(1'b0, 1'b1, WAKE_NIB, sw, 1'b0);
                add_step(1'b0, 1'b1, MODE_4BIT_NIB, sw, 1'b0);
                add_byte(1'b0, FUNC_SET_4BIT, sw, 1'b0);
                add_byte(1'b0, DISPLAY_OFF, sw, 1'b0);
                add_byte(1'b0, CMD_CLEAR, clear_wait_us(), 1'b0);
                add_byte(1'b0, ENTRY_INC, sw, 1'b0);
                add_byte(1'b0, DISPLAY_ON, sw, 1'b1);
            end
        endcase
    endfunction

    // hand one command to the block and record what it should produce
    task automatic send_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                                input logic typed, input logic rs,
                                input logic [NIB_W-1:0] hi, input logic [NIB_W-1:0] lo,
                                input logic [WAIT_W-1:0] wait_us);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col, ch};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) begin
            add_step(rs, 1'b1, hi, wait_us, 1'b0);
            add_step(rs, 1'b1, lo, wait_us, 1'b1);
        end else begin
            expand_command(op, ch, col, row);
        end
    endtask

    // stop sending and wait for every outstanding step
    task automatic drain_steps();
        s_axis_tvalid <= 1'b0;
        while (steps_pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_std_wait(input logic [CFG_W-1:0] value);
        drain_steps();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        std_wait_us = value;
    endtask

    // receiver ready, switching between stall patterns
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (stall_tick % 4) != 0;
            default: m_axis_tready <= (stall_tick % 7) < 2;
        endcase
    end

    // compare each output transaction with the oldest expected step
    always @(posedge i_clk) begin
        t_step want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (steps_pending.size() == 0) begin
                report_mismatch($sformatf("unexpected step nib=%h wait=%0d",
                                          m_axis_tdata[3:0], m_axis_tdata[17:4]));
            end else begin
                want = steps_pending.pop_front();
                if (m_axis_tuser[0] !== want.rs || m_axis_tuser[1] !== want.strobe ||
                    m_axis_tdata[3:0] !== want.nibble ||
                    m_axis_tdata[17:4] !== want.wait_us || m_axis_tlast !== want.last)
                    report_mismatch($sformatf(
                        "step rs/strobe/nib/wait/last got %b/%b/%h/%0d/%b exp %b/%b/%h/%0d/%b",
                        m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[3:0],
                        m_axis_tdata[17:4], m_axis_tlast, want.rs, want.strobe,
                        want.nibble, want.wait_us, want.last));
            end
        end
    end

    // stimulus
    initial begin
        t_script_row script [SCRIPT_LEN];
        int          burst_left;
        int          gap;
        logic [OP_W-1:0] op;
        script = '{
            '{1'b0, 9'd0,   OP_PRINT,  8'h00, 6'd0,  2'd0,      1'b1, 1'b1, 4'h0, 4'h0, 14'd40},
            '{1'b0, 9'd0,   OP_PRINT,  8'hFF, 6'd63, 2'd3,      1'b1, 1'b1, 4'hF, 4'hF, 14'd40},
            '{1'b0, 9'd0,   OP_PRINT,  8'hA5, 6'd0,  2'd0,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0},
            '{1'b0, 9'd0,   OP_CLEAR,  8'h00, 6'd0,  2'd0,      1'b1, 1'b0, 4'h0, 4'h1, 14'd1640},
            '{1'b0, 9'd0,   OP_CURSOR, 8'h00, 6'd0,  2'd0,      1'b1, 1'b0, 4'h8, 4'h0, 14'd40},
            '{1'b0, 9'd0,   OP_CURSOR, 8'h00, 6'd63, ROW_LINE2, 1'b1, 1'b0, 4'hF, 4'hF, 14'd40},
            '{1'b0, 9'd0,   OP_CURSOR, 8'hFF, 6'd63, 2'd3,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0},
            '{1'b0, 9'd0,   OP_CURSOR, 8'h00, 6'd42, 2'd1,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0},
            '{1'b0, 9'd0,   OP_INIT,   8'h00, 6'd0,  2'd0,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0},
            '{1'b0, 9'd0,   OP_PRINT,  8'h5A, 6'd0,  2'd0,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0},
            '{1'b1, 9'd0,   OP_CLEAR,  8'h00, 6'd0,  2'd0,      1'b1, 1'b0, 4'h0, 4'h1, 14'd0},
            '{1'b0, 9'd0,   OP_INIT,   8'hFF, 6'd63, 2'd3,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0},
            '{1'b0, 9'd0,   OP_PRINT,  8'h3C, 6'd0,  2'd0,      1'b1, 1'b1, 4'h3, 4'hC, 14'd0},
            '{1'b1, 9'd511, OP_CLEAR,  8'h00, 6'd0,  2'd0,      1'b1, 1'b0, 4'h0, 4'h1, 14'd16383},
            '{1'b0, 9'd0,   OP_INIT,   8'h00, 6'd0,  2'd0,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0},
            '{1'b0, 9'd0,   OP_CURSOR, 8'h00, 6'd5,  ROW_LINE2, 1'b1, 1'b0, 4'hC, 4'h5, 14'd511},
            '{1'b1, 9'd400, OP_CLEAR,  8'h00, 6'd0,  2'd0,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0},
            '{1'b1, 9'd1,   OP_PRINT,  8'h81, 6'd0,  2'd0,      1'b1, 1'b1, 4'h8, 4'h1, 14'd1},
            '{1'b1, 9'd360, OP_CLEAR,  8'h00, 6'd0,  2'd0,      1'b1, 1'b0, 4'h0, 4'h1, 14'd14760},
            '{1'b0, 9'd0,   OP_INIT,   8'h00, 6'd0,  2'd0,      1'b0, 1'b0, 4'h0, 4'h0, 14'd0}
        };

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (script[i].wr_cfg)
                write_std_wait(script[i].cfg);
            send_command(script[i].op, script[i].ch, script[i].col, script[i].row,
                         script[i].typed, script[i].rs, script[i].hi, script[i].lo,
                         script[i].wait_us);
        end

        // random phases, each under its own standard wait
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       write_std_wait(9'd511);
                1:       write_std_wait(9'd0);
                default: write_std_wait(CFG_W'($urandom_range(0, 511)));
            endcase
            burst_left = 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // sender pauses until the block has emptied
                if (p == 2 && i == PHASE_ITEMS / 2)
                    drain_steps();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst_left--;
                op = OP_W'($urandom_range(0, 3));
                send_command(op, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom),
                             1'b0, 1'b0, '0, '0, '0);
            end
        end

        // wait out the last results
        drain_steps();
        repeat (20) @(posedge i_clk);
        if (steps_pending.size() != 0)
            report_mismatch($sformatf("%0d expected steps never arrived",
                                      steps_pending.size()));
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/clns_pkg.sv
design/clns_front.sv
design/clns_queue.sv
design/clns_back.sv
design/char_lcd_nibble_sequencer.sv
dv/tb.sv
